FILE: rtl/spq_pkg.sv
// spq_pkg: shared constants and types of the sorted priority queue
// operation and status codes, default sizes, cell control struct
// no dependencies
package spq_pkg;

	localparam int DEPTH_DEF       = 16;
	localparam int VALUE_WIDTH_DEF = 32;

	// fixed field widths of the result word
	localparam int OP_W     = 2;
	localparam int STATUS_W = 2;
	localparam int POS_W    = 4;
	localparam int COUNT_W  = 5;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
	localparam logic [OP_W-1:0] OP_FIND   = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

	// command broadcast to every cell of the chain
	typedef struct packed {
		logic ins;  // open a slot at the boundary and shift the tail up
		logic rem;  // drop the boundary entry and shift the tail down
	} cell_ctrl_t;

endpackage

FILE: rtl/spq_cell.sv
// spq_cell: one slot of the sorted chain, holds an entry and its valid bit
// compares against the broadcast value and shifts to or from its neighbours
// depends on spq_pkg
module spq_cell #(
	parameter int VALUE_WIDTH = spq_pkg::VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  spq_pkg::cell_ctrl_t    ctrl,
	input  logic [VALUE_WIDTH-1:0] value,
	input  logic                   lt_prev,
	input  logic [VALUE_WIDTH-1:0] left_data,
	input  logic                   left_valid,
	input  logic [VALUE_WIDTH-1:0] right_data,
	input  logic                   right_valid,
	output logic [VALUE_WIDTH-1:0] data,
	output logic                   valid,
	output logic                   lt,
	output logic                   eq,
	output logic                   bound
);
	import spq_pkg::*;

	logic [VALUE_WIDTH-1:0] data_q;
	logic                   valid_q;
	logic [VALUE_WIDTH-1:0] data_d;
	logic                   valid_d;

	assign lt    = valid_q && ($signed(data_q) < $signed(value));
	assign eq    = valid_q && (data_q == value);
	// chain is sorted, so lt is a thermometer: boundary is its falling edge
	assign bound = !lt && lt_prev;

	always_comb begin
		data_d  = data_q;
		valid_d = valid_q;
		if (ctrl.ins) begin
			if (bound) begin
				data_d  = value;
				valid_d = 1'b1;
			end else if (!lt) begin
				data_d  = left_data;
				valid_d = left_valid;
			end
		end else if (ctrl.rem) begin
			if (!lt) begin
				data_d  = right_data;
				valid_d = right_valid;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data  = data_q;
	assign valid = valid_q;

endmodule

FILE: rtl/sorted_priority_queue_core.sv
// sorted_priority_queue_core: top level of the sorted priority queue
// a chain of spq_cell slots with input, result and output registers
// depends on spq_pkg and spq_cell
//
// usage
//   s_axis carries one operation per word: insert, remove or find of a signed
//   value. m_axis returns exactly one result word per operation: status,
//   position, head of the queue, head valid flag and entry count after it.
//   the entries live in a row of DEPTH cells kept in ascending order; every
//   cell compares itself with the broadcast value in the same cycle, so the
//   insert point or the first match is found without a search loop, and the
//   tail of the row shifts up or down by one slot in that cycle.
// operation flow
//   after the accept the cells compare and update, and status and position
//   are captured in the result stage. head and count are then read into the
//   output register, and m_axis_tvalid rises at the edge that loads it. one
//   operation is in flight at a time, so a new word is taken only once the
//   previous result has moved to the output register; the limit is the read
//   of the head from the first cell after the update.
// reset and stalls
//   arst_n empties the queue (all cell valid bits and the count clear) and
//   drops any word in flight. while m_axis is stalled the result stays in the
//   output register; one further word can be accepted and processed, then
//   s_axis_tready stays low until the held result is taken.
module sorted_priority_queue_core #(
	parameter int DEPTH       = spq_pkg::DEPTH_DEF,
	parameter int VALUE_WIDTH = spq_pkg::VALUE_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// fields from bit 0: operation, value
	input  logic [((VALUE_WIDTH+spq_pkg::OP_W+7)/8)*8-1:0] s_axis_tdata,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// fields from bit 0: status, position, head_value, head_valid, entry_count
	output logic [((VALUE_WIDTH+12+7)/8)*8-1:0]   m_axis_tdata
);
	import spq_pkg::*;

	localparam int RES_W = STATUS_W + POS_W + VALUE_WIDTH + 1 + COUNT_W;
	localparam int OUT_W = ((VALUE_WIDTH + 12 + 7) / 8) * 8;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	// input register
	logic                   v_s1;
	logic [OP_W-1:0]        op_s1;
	logic [VALUE_WIDTH-1:0] value_s1;

	// result stage
	logic                   v_s2;
	logic [STATUS_W-1:0]    status_s2;
	logic [POS_W-1:0]       pos_s2;

	// output register
	logic                   out_valid_q;
	logic [RES_W-1:0]       out_word_q;

	logic [CNT_W-1:0]       count_q;

	// chain wiring
	logic [VALUE_WIDTH-1:0] cell_data  [DEPTH];
	logic                   cell_valid [DEPTH];
	logic                   cell_lt    [DEPTH];
	logic                   cell_eq    [DEPTH];
	logic                   cell_bound [DEPTH];
	cell_ctrl_t             ctrl;

	logic                   in_acc;
	logic                   out_load;
	logic                   full;
	logic                   hit;
	logic [IDX_W-1:0]       bound_idx;
	logic [IDX_W+POS_W-1:0] bound_idx_wide;
	logic [STATUS_W-1:0]    status_d;
	logic [POS_W-1:0]       pos_d;
	logic [CNT_W+COUNT_W-1:0] count_wide;
	logic [VALUE_WIDTH-1:0] head_value;

	assign s_axis_tready = !v_s1 && !v_s2;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_load      = v_s2 && (!out_valid_q || m_axis_tready);
	assign full          = (count_q == CNT_W'(DEPTH));

	// one cell per slot, neighbours wired left to right
	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		logic [VALUE_WIDTH-1:0] left_data;
		logic                   left_valid;
		logic [VALUE_WIDTH-1:0] right_data;
		logic                   right_valid;
		logic                   lt_prev;

		if (k == 0) begin : g_first
			assign left_data  = '0;
			assign left_valid = 1'b0;
			assign lt_prev    = 1'b1;
		end else begin : g_inner
			assign left_data  = cell_data[k-1];
			assign left_valid = cell_valid[k-1];
			assign lt_prev    = cell_lt[k-1];
		end

		if (k == DEPTH - 1) begin : g_last
			assign right_data  = '0;
			assign right_valid = 1'b0;
		end else begin : g_body
			assign right_data  = cell_data[k+1];
			assign right_valid = cell_valid[k+1];
		end

		spq_cell #(
			.VALUE_WIDTH(VALUE_WIDTH)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.value      (value_s1),
			.lt_prev    (lt_prev),
			.left_data  (left_data),
			.left_valid (left_valid),
			.right_data (right_data),
			.right_valid(right_valid),
			.data       (cell_data[k]),
			.valid      (cell_valid[k]),
			.lt         (cell_lt[k]),
			.eq         (cell_eq[k]),
			.bound      (cell_bound[k])
		);
	end

	// boundary is at most one-hot, so its index and the match flag are plain or-trees
	always_comb begin
		bound_idx = '0;
		hit       = 1'b0;
		for (int k = 0; k < DEPTH; k++) begin
			if (cell_bound[k]) begin
				bound_idx = bound_idx | IDX_W'(k);
			end
			hit = hit | (cell_bound[k] && cell_eq[k]);
		end
	end

	// position keeps only its low bits when the chain is deeper than 16
	assign bound_idx_wide = (IDX_W + POS_W)'(bound_idx);

	always_comb begin
		ctrl.ins = 1'b0;
		ctrl.rem = 1'b0;
		status_d = ST_MISS;
		pos_d    = '0;
		case (op_s1)
			OP_INSERT: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					ctrl.ins = v_s1;
					status_d = ST_OK;
					pos_d    = bound_idx_wide[POS_W-1:0];
				end
			end
			OP_REMOVE: begin
				if (hit) begin
					ctrl.rem = v_s1;
					status_d = ST_OK;
					pos_d    = bound_idx_wide[POS_W-1:0];
				end
			end
			OP_FIND: begin
				if (hit) begin
					status_d = ST_OK;
					pos_d    = bound_idx_wide[POS_W-1:0];
				end
			end
			default: begin
				status_d = ST_MISS;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			if (in_acc) begin
				v_s1 <= 1'b1;
			end else if (v_s1) begin
				v_s1 <= 1'b0;
			end

			if (v_s1) begin
				v_s2 <= 1'b1;
			end else if (out_load) begin
				v_s2 <= 1'b0;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			if (ctrl.ins) begin
				count_q <= count_q + 1'b1;
			end else if (ctrl.rem) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_s1    <= s_axis_tdata[OP_W-1:0];
			value_s1 <= s_axis_tdata[OP_W+VALUE_WIDTH-1:OP_W];
		end
		if (v_s1) begin
			status_s2 <= status_d;
			pos_s2    <= pos_d;
		end
		if (out_load) begin
			out_word_q <= {count_wide[COUNT_W-1:0], cell_valid[0], head_value,
				pos_s2, status_s2};
		end
	end

	// head and count are read after the cells have settled
	assign head_value = cell_valid[0] ? cell_data[0] : '0;
	assign count_wide = (CNT_W + COUNT_W)'(count_q);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_W'(out_word_q);

	// checks
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count beyond chain depth");

	a_head_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		cell_valid[0] == (count_q != '0))
		else $error("first cell valid disagrees with entry count");

	a_single_flight: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> !v_s2)
		else $error("two operations in flight");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> v_s1 && !s_axis_tready)
		else $error("accepted word did not enter the compare stage");

	a_load_flags_head: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_word_q[STATUS_W+POS_W+VALUE_WIDTH] == (count_q != '0))
		else $error("head valid flag disagrees with entry count");

endmodule
